>>> rtl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants of the battery fault monitor: register
// indexes, fault flag positions and stream widths.
// ----------------------------------------------------------------------------
package bfm_pkg;

    // debounce counter width
    localparam int CNT_W = 16;

    // fault flag vector
    localparam int FLAG_W      = 6;
    localparam int F_STALE     = 0;
    localparam int F_STALE_OFF = 1;
    localparam int F_OV        = 2;
    localparam int F_UV        = 3;
    localparam int F_OT        = 4;
    localparam int F_UT        = 5;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_AGE     = 3'd0,
        REG_MAX_AGE_OFF = 3'd1,
        REG_END_CHARGE  = 3'd2,
        REG_CUTOFF      = 3'd3,
        REG_R_INT_FULL  = 3'd4,
        REG_R_INT_EMPTY = 3'd5,
        REG_MAX_TEMP    = 3'd6,
        REG_MIN_TEMP    = 3'd7
    } t_cfg_reg;

    // stream widths: 137 payload bits padded to whole bytes
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 8;

    // scale of the resistive drop: mA * mOhm / SCALE = mV
    localparam int SCALE = 1000;

endpackage

>>> rtl/bfm_debounce.sv
// ----------------------------------------------------------------------------
// bfm_debounce
// Saturating debounce counter for one fault condition; reports whether the
// updated count exceeds the limit.
// ----------------------------------------------------------------------------
module bfm_debounce #(
    parameter int unsigned LIMIT = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clear,   // zero the count
    input  logic i_update,  // apply i_hit this cycle
    input  logic i_hit,     // condition present
    output logic o_trip     // count after this update is above the limit
);
    import bfm_pkg::*;

    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);
    localparam logic [CNT_W-1:0] SAT_C   = CNT_W'(LIMIT + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        if (!i_hit) begin
            n_cnt = '0;
        end else if (r_cnt < SAT_C) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    assign o_trip = (n_cnt > LIMIT_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cnt <= '0;
        end else if (i_update) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/battery_fault_monitor.sv
// ----------------------------------------------------------------------------
// battery_fault_monitor
// Debounced battery protection faults: stale data, compensated over- and
// under-voltage, over- and under-temperature.
// ----------------------------------------------------------------------------
// Each input transaction is a check tick (tuser = 0) or a clear (tuser = 1),
// and each produces exactly one output transaction carrying the six sticky
// fault flags after the update. The block runs a three-stage pipeline: an
// input register, a stage that forms the data age, the current-times-
// resistance products and the scaled voltage margins, and the result stage
// that finishes the compares, steps the four debounce counters and updates
// the fault flags. Throughput is one transaction per clock while
// m_axis_tready does not hold the output. Every stage collapses bubbles,
// so input is accepted while a finished result waits downstream, as long
// as an earlier stage is empty. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_data and must only be changed while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module battery_fault_monitor #(
    parameter int unsigned ERROR_COUNT_LIMIT = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [bfm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bfm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: now_ms[31:0], oldest_stamp_ms[31:0], max_cell_mv[15:0],
    // min_cell_mv[15:0], current_ma[18:0], temp_a[10:0], temp_b[10:0], zero pad
    input  logic [bfm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser: op (0 check tick, 1 clear)
    input  logic                              s_axis_tuser,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: stale_fault, stale_off_fault, over_voltage_fault,
    // under_voltage_fault, over_temp_fault, under_temp_fault, zero pad
    output logic [bfm_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import bfm_pkg::*;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [31:0]        r_max_age;
    logic [31:0]        r_max_age_off;
    logic [15:0]        r_end_charge;
    logic [15:0]        r_cutoff;
    logic [9:0]         r_r_full;
    logic [9:0]         r_r_empty;
    logic signed [10:0] r_max_temp;
    logic signed [10:0] r_min_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age     <= 32'd1000;
            r_max_age_off <= 32'd5000;
            r_end_charge  <= 16'd4200;
            r_cutoff      <= 16'd3000;
            r_r_full      <= 10'd10;
            r_r_empty     <= 10'd10;
            r_max_temp    <= 11'sd60;
            r_min_temp    <= -11'sd20;
        end else if (i_cfg_we) begin
            // keep only the register's own width
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_MAX_AGE:     r_max_age     <= i_cfg_data;
                REG_MAX_AGE_OFF: r_max_age_off <= i_cfg_data;
                REG_END_CHARGE:  r_end_charge  <= i_cfg_data[15:0];
                REG_CUTOFF:      r_cutoff      <= i_cfg_data[15:0];
                REG_R_INT_FULL:  r_r_full      <= i_cfg_data[9:0];
                REG_R_INT_EMPTY: r_r_empty     <= i_cfg_data[9:0];
                REG_MAX_TEMP:    r_max_temp    <= $signed(i_cfg_data[10:0]);
                REG_MIN_TEMP:    r_min_temp    <= $signed(i_cfg_data[10:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control: each stage loads when it is empty or drains
    // ------------------------------------------------------------------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic en2;
    logic en3;
    logic load3;

    assign en3           = !r_out_valid || m_axis_tready;
    assign en2           = !r_s2_valid || en3;
    assign s_axis_tready = !r_s1_valid || en2;
    assign load3         = en3 && r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en3) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------------
    logic               r_s1_op;
    logic [31:0]        r_s1_now;
    logic [31:0]        r_s1_stamp;
    logic [15:0]        r_s1_vmax;
    logic [15:0]        r_s1_vmin;
    logic signed [18:0] r_s1_cur;
    logic signed [10:0] r_s1_ta;
    logic signed [10:0] r_s1_tb;

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_op    <= s_axis_tuser;
            r_s1_now   <= s_axis_tdata[31:0];
            r_s1_stamp <= s_axis_tdata[63:32];
            r_s1_vmax  <= s_axis_tdata[79:64];
            r_s1_vmin  <= s_axis_tdata[95:80];
            r_s1_cur   <= $signed(s_axis_tdata[114:96]);
            r_s1_ta    <= $signed(s_axis_tdata[125:115]);
            r_s1_tb    <= $signed(s_axis_tdata[136:126]);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: data age, resistive drop products, scaled voltage margins.
    // With q = trunc(p / SCALE) and margin m, the test q < m becomes
    // p < SCALE*m for p >= 0 and p <= SCALE*m - SCALE for p < 0, so no
    // divider is needed.
    // ------------------------------------------------------------------------
    logic [31:0]        age;
    logic               n_stale;
    logic               n_stale_off;
    logic signed [16:0] d_ov;
    logic signed [16:0] d_uv;
    logic signed [28:0] n_p_full;
    logic signed [28:0] n_p_empty;
    logic signed [26:0] n_t_ov;
    logic signed [26:0] n_t_uv;
    logic               n_ot_hit;
    logic               n_ut_hit;

    assign age         = r_s1_now - r_s1_stamp;
    assign n_stale     = (age > r_max_age);
    assign n_stale_off = (age > r_max_age_off);

    // over-voltage: vmax - q > eoc  <=>  q < vmax - eoc
    // under-voltage: vmin + q < cutoff  <=>  q < cutoff - vmin
    assign d_ov = $signed({1'b0, r_s1_vmax}) - $signed({1'b0, r_end_charge});
    assign d_uv = $signed({1'b0, r_cutoff}) - $signed({1'b0, r_s1_vmin});

    assign n_p_full  = $signed({{10{r_s1_cur[18]}}, r_s1_cur}) * $signed({19'd0, r_r_full});
    assign n_p_empty = $signed({{10{r_s1_cur[18]}}, r_s1_cur}) * $signed({19'd0, r_r_empty});

    assign n_t_ov = $signed({{10{d_ov[16]}}, d_ov}) * 27'(SCALE);
    assign n_t_uv = $signed({{10{d_uv[16]}}, d_uv}) * 27'(SCALE);

    // both sensors must agree
    assign n_ot_hit = (r_s1_ta > r_max_temp) && (r_s1_tb > r_max_temp);
    assign n_ut_hit = (r_s1_ta < r_min_temp) && (r_s1_tb < r_min_temp);

    logic               r_s2_op;
    logic               r_s2_stale;
    logic               r_s2_stale_off;
    logic signed [28:0] r_s2_p_full;
    logic signed [28:0] r_s2_p_empty;
    logic signed [26:0] r_s2_t_ov;
    logic signed [26:0] r_s2_t_uv;
    logic               r_s2_ot_hit;
    logic               r_s2_ut_hit;

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_valid) begin
            r_s2_op        <= r_s1_op;
            r_s2_stale     <= n_stale;
            r_s2_stale_off <= n_stale_off;
            r_s2_p_full    <= n_p_full;
            r_s2_p_empty   <= n_p_empty;
            r_s2_t_ov      <= n_t_ov;
            r_s2_t_uv      <= n_t_uv;
            r_s2_ot_hit    <= n_ot_hit;
            r_s2_ut_hit    <= n_ut_hit;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: finish the voltage compares, step the counters, update flags
    // ------------------------------------------------------------------------
    function automatic logic drop_below(input logic signed [28:0] p,
                                        input logic signed [26:0] t);
        logic signed [29:0] p_x;
        logic signed [29:0] t_x;
        p_x = {p[28], p};
        t_x = {{3{t[26]}}, t};
        if (p[28]) begin
            drop_below = (p_x + 30'(SCALE)) <= t_x;
        end else begin
            drop_below = p_x < t_x;
        end
    endfunction

    logic ov_hit;
    logic uv_hit;
    logic cnt_clear;
    logic cnt_update;
    logic ov_trip;
    logic uv_trip;
    logic ot_trip;
    logic ut_trip;

    assign ov_hit     = drop_below(r_s2_p_full, r_s2_t_ov);
    assign uv_hit     = drop_below(r_s2_p_empty, r_s2_t_uv);
    assign cnt_clear  = load3 && r_s2_op;
    // stale data leaves the counters alone
    assign cnt_update = load3 && !r_s2_op && !r_s2_stale;

    bfm_debounce #(.LIMIT(ERROR_COUNT_LIMIT)) u_ov_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cnt_clear),
        .i_update (cnt_update),
        .i_hit    (ov_hit),
        .o_trip   (ov_trip)
    );

    bfm_debounce #(.LIMIT(ERROR_COUNT_LIMIT)) u_uv_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cnt_clear),
        .i_update (cnt_update),
        .i_hit    (uv_hit),
        .o_trip   (uv_trip)
    );

    bfm_debounce #(.LIMIT(ERROR_COUNT_LIMIT)) u_ot_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cnt_clear),
        .i_update (cnt_update),
        .i_hit    (r_s2_ot_hit),
        .o_trip   (ot_trip)
    );

    bfm_debounce #(.LIMIT(ERROR_COUNT_LIMIT)) u_ut_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cnt_clear),
        .i_update (cnt_update),
        .i_hit    (r_s2_ut_hit),
        .o_trip   (ut_trip)
    );

    // sticky flags double as the result register: they change only when a
    // transaction enters the output stage
    logic [FLAG_W-1:0] r_flags;
    logic [FLAG_W-1:0] n_flags;
    logic [FLAG_W-1:0] set_mask;

    always_comb begin
        set_mask = '0;
        if (r_s2_stale) begin
            set_mask[F_STALE]     = 1'b1;
            set_mask[F_STALE_OFF] = r_s2_stale_off;
        end else begin
            set_mask[F_OV] = ov_trip;
            set_mask[F_UV] = uv_trip;
            set_mask[F_OT] = ot_trip;
            set_mask[F_UT] = ut_trip;
        end
        if (r_s2_op) begin
            n_flags = '0;
        end else begin
            n_flags = r_flags | set_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (load3) begin
            r_flags <= n_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - FLAG_W)'(0), r_flags};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load3 && r_s2_op) |=> (r_flags == '0))
        else $error("clear did not zero the fault flags");

    a_stale_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load3 && !r_s2_op && r_s2_stale) |=> r_flags[F_STALE])
        else $error("stale transaction did not set the stale flag");

    a_off_implies_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[F_STALE_OFF] |-> r_flags[F_STALE])
        else $error("off-state stale flag set without stale flag");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load3 |=> $stable(r_flags))
        else $error("fault flags changed without a result load");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_flags)))
        else $error("pending result changed while stalled");

endmodule
